// ===== design/amai_pkg.sv =====
// Shared constants, types and helpers for the adaptive moving average block.
`default_nettype none
package amai_pkg;

  localparam int SampleBits = 16;
  localparam int MaxWindow  = 64;
  localparam int PosBits    = $clog2(MaxWindow);
  localparam int WinBits    = PosBits + 1;
  localparam int ScBits     = 17;
  localparam int DiffBits   = SampleBits + 1;
  localparam int VolBits    = DiffBits + PosBits;
  localparam int AvgBits    = SampleBits + 16;
  localparam int GapBits    = AvgBits + 2;
  localparam int ProdBits   = ScBits + 1 + GapBits;
  localparam int RemBits    = VolBits + 1;
  localparam int CfgIdxBits = 2;

  localparam logic [ScBits-1:0] ScOne = ScBits'(65536);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_WINDOW  = 2'd0,
    CFG_FAST_SC = 2'd1,
    CFG_SLOW_SC = 2'd2,
    CFG_UNUSED  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_RD_C,
    S_EVAL,
    S_DIV_INIT,
    S_DIV,
    S_LIN_M,
    S_LIN,
    S_SQ_M,
    S_SQ,
    S_UPD_M,
    S_UPD,
    S_DONE
  } state_t;

  function automatic logic [ScBits-1:0] clamp_sc(input logic [ScBits-1:0] v);
    return (v > ScOne) ? ScOne : v;
  endfunction

  function automatic logic [DiffBits-1:0] abs_diff(input logic signed [SampleBits-1:0] a,
                                                   input logic signed [SampleBits-1:0] b);
    logic signed [DiffBits-1:0] d;
    d = DiffBits'(a) - DiffBits'(b);
    return d[DiffBits-1] ? DiffBits'(-d) : DiffBits'(d);
  endfunction

endpackage
`default_nettype wire

// ===== design/adaptive_moving_average_iq.sv =====
// Top level: Kaufman adaptive moving average on I/Q samples, shared divider and multiplier.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  input   | in_valid / in_stall  | sample_i, sample_q, channel_start
//  output  | out_valid / out_stall| out_i, out_q, warming
//  config  | cfg_we               | cfg_index, cfg_data
//
// A warm-up request passes the RAM read states, the evaluate state and the output state
// before the input is free again. A filtering request passes the RAM read states
// S_RD_A, S_RD_B and S_RD_C and the evaluate state, then per component divider setup,
// a restoring divider for the 17-bit efficiency ratio and three passes through the one
// shared 18x34 multiplier, then the output state and the idle state.
// Synchronous reset clears control state and sets the registers to their defaults;
// the sample and difference rings are not cleared.
// in_stall is low only in the idle state; a finished result waits in a holding
// stage while the output register is still stalled.
`default_nettype none
module adaptive_moving_average_iq
  import amai_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SampleBits-1:0]  sample_i,
  input  wire logic signed [SampleBits-1:0]  sample_q,
  input  wire logic                          channel_start,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SampleBits-1:0]       out_i,
  output logic signed [SampleBits-1:0]       out_q,
  output logic                               warming,
  input  wire logic                          cfg_we,
  input  wire logic [CfgIdxBits-1:0]         cfg_index,
  input  wire logic [ScBits-1:0]             cfg_data
);

  // configuration registers
  logic [WinBits-1:0] win_period;
  logic [ScBits-1:0]  fast_sc;
  logic [ScBits-1:0]  slow_sc;

  state_t state, state_next;

  // request and channel state
  logic signed [SampleBits-1:0] x_i, x_q;
  logic [WinBits-1:0] window_len;
  logic [PosBits-1:0] ring_pos;
  logic [WinBits-1:0] warm_count;
  logic [VolBits-1:0] volatility_i, volatility_q;
  logic signed [AvgBits-1:0] average_i, average_q;

  // ring read captures
  logic signed [SampleBits-1:0] old_i, old_q, prv_i, prv_q;
  logic [DiffBits-1:0] dold_i, dold_q;
  logic [DiffBits-1:0] dir_i, dir_q;

  // shared arithmetic
  logic                       comp;
  logic [RemBits-1:0]         rem;
  logic [ScBits-1:0]          quo;
  logic [4:0]                 div_cnt;
  logic [ScBits-1:0]          lin, sc;
  logic [ScBits-1:0]          mul_a;
  logic signed [GapBits-1:0]  mul_b;
  logic signed [ProdBits-1:0] prod;

  // result holding stage
  logic signed [SampleBits-1:0] res_i, res_q;
  logic                         res_warm;

  // RAM ports
  logic                         ring_we;
  logic [PosBits-1:0]           s_raddr;
  logic [2*SampleBits-1:0]      s_rdata;
  logic [2*DiffBits-1:0]        d_rdata;
  logic [DiffBits-1:0]          d_i, d_q;

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  logic [PosBits-1:0] prev_pos;
  assign prev_pos = (ring_pos == '0) ? PosBits'(window_len - 1'b1) : ring_pos - 1'b1;

  logic [WinBits-1:0] er_clamped;
  assign er_clamped = (win_period == '0) ? WinBits'(1) :
                      (win_period > WinBits'(MaxWindow)) ? WinBits'(MaxWindow) : win_period;

  logic is_warm;
  assign is_warm = (warm_count < window_len);

  // differences for this request; the first sample of a channel has none
  assign d_i = (warm_count == '0) ? '0 : abs_diff(x_i, prv_i);
  assign d_q = (warm_count == '0) ? '0 : abs_diff(x_q, prv_q);

  // per-component selection
  logic [VolBits-1:0]           vol_c;
  logic [DiffBits-1:0]          dir_c;
  logic signed [SampleBits-1:0] x_c;
  logic signed [AvgBits-1:0]    avg_c;
  assign vol_c = comp ? volatility_q : volatility_i;
  assign dir_c = comp ? dir_q : dir_i;
  assign x_c   = comp ? x_q : x_i;
  assign avg_c = comp ? average_q : average_i;

  logic [ScBits-1:0] fs, ss;
  assign fs = clamp_sc(fast_sc);
  assign ss = clamp_sc(slow_sc);

  logic signed [GapBits-1:0] gap;
  assign gap = $signed({{2{x_c[SampleBits-1]}}, x_c, 16'b0}) -
               $signed({{(GapBits-AvgBits){avg_c[AvgBits-1]}}, avg_c});

  // rounding adders fed by the product register
  logic signed [ProdBits-1:0] lin_acc, prod_rnd;
  assign lin_acc  = $signed({{(ProdBits-ScBits-16){1'b0}}, ss, 16'b0}) + prod
                    + ProdBits'(32768);
  assign prod_rnd = prod + ProdBits'(32768);

  logic signed [AvgBits-1:0] avg_new;
  logic signed [AvgBits:0]   out_rnd;
  logic signed [SampleBits:0] out_wide;
  logic signed [SampleBits-1:0] out_sat;
  assign avg_new  = avg_c + AvgBits'(prod_rnd >>> 16);
  assign out_rnd  = (AvgBits + 1)'(avg_new) + (AvgBits + 1)'(32768);
  assign out_wide = out_rnd[AvgBits:16];
  assign out_sat  = (out_wide > (SampleBits + 1)'((1 << (SampleBits - 1)) - 1)) ?
                      SampleBits'((1 << (SampleBits - 1)) - 1) :
                    (out_wide < -(SampleBits + 1)'(1 << (SampleBits - 1))) ?
                      SampleBits'(1 << (SampleBits - 1)) : SampleBits'(out_wide);

  logic div_sub;
  assign div_sub = (rem >= RemBits'(vol_c));

  amai_ram #(.Width(2 * SampleBits), .Depth(MaxWindow)) u_sample_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_pos),
    .wdata ({x_q, x_i}),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  amai_ram #(.Width(2 * DiffBits), .Depth(MaxWindow)) u_diff_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_pos),
    .wdata ({d_q, d_i}),
    .raddr (ring_pos),
    .rdata (d_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (accept) state_next = S_RD_A;
      S_RD_A:     state_next = S_RD_B;
      S_RD_B:     state_next = S_RD_C;
      S_RD_C:     state_next = S_EVAL;
      S_EVAL:     state_next = is_warm ? S_DONE : S_DIV_INIT;
      S_DIV_INIT: state_next = S_DIV;
      S_DIV:      if (div_cnt == '0) state_next = S_LIN_M;
      S_LIN_M:    state_next = S_LIN;
      S_LIN:      state_next = S_SQ_M;
      S_SQ_M:     state_next = S_SQ;
      S_SQ:       state_next = S_UPD_M;
      S_UPD_M:    state_next = S_UPD;
      S_UPD:      state_next = comp ? S_DONE : S_DIV_INIT;
      S_DONE:     if (!out_valid || !out_stall) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // decoded controls: RAM addressing, write strobe, multiplier operands
  always_comb begin
    ring_we = 1'b0;
    s_raddr = ring_pos;
    mul_a   = '0;
    mul_b   = '0;
    unique case (state)
      S_RD_B:  s_raddr = prev_pos;
      S_EVAL:  ring_we = 1'b1;
      S_LIN_M: begin
        mul_a = (vol_c == '0) ? '0 : quo;
        mul_b = GapBits'($signed({1'b0, fs}) - $signed({1'b0, ss}));
      end
      S_SQ_M: begin
        mul_a = lin;
        mul_b = $signed({{(GapBits-ScBits){1'b0}}, lin});
      end
      S_UPD_M: begin
        mul_a = sc;
        mul_b = gap;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      win_period   <= WinBits'(10);
      fast_sc      <= ScBits'(43691);
      slow_sc      <= ScBits'(4228);
      window_len   <= WinBits'(1);
      ring_pos     <= '0;
      warm_count   <= '0;
      volatility_i <= '0;
      volatility_q <= '0;
      average_i    <= '0;
      average_q    <= '0;
      out_valid    <= 1'b0;
      comp         <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_WINDOW:  win_period <= cfg_data[WinBits-1:0];
          CFG_FAST_SC: fast_sc    <= cfg_data;
          CFG_SLOW_SC: slow_sc    <= cfg_data;
          CFG_UNUSED:  ;
          default:     ;
        endcase
      end

      // drop the output once taken, unless a new result replaces it
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: if (accept) begin
          // a channel start, or the first sample after reset, restarts the channel
          if (channel_start || warm_count == '0) begin
            window_len   <= er_clamped;
            ring_pos     <= '0;
            volatility_i <= '0;
            volatility_q <= '0;
            warm_count   <= '0;
          end
        end
        S_RD_B: begin
          old_i  <= s_rdata[SampleBits-1:0];
          old_q  <= s_rdata[2*SampleBits-1:SampleBits];
          dold_i <= d_rdata[DiffBits-1:0];
          dold_q <= d_rdata[2*DiffBits-1:DiffBits];
        end
        S_RD_C: begin
          prv_i <= s_rdata[SampleBits-1:0];
          prv_q <= s_rdata[2*SampleBits-1:SampleBits];
        end
        S_EVAL: begin
          dir_i <= abs_diff(x_i, old_i);
          dir_q <= abs_diff(x_q, old_q);
          comp  <= 1'b0;
          if (is_warm) begin
            volatility_i <= volatility_i + VolBits'(d_i);
            volatility_q <= volatility_q + VolBits'(d_q);
            if (warm_count == window_len - 1'b1) begin
              // seed the average from the last warm-up sample
              average_i <= {x_i, 16'b0};
              average_q <= {x_q, 16'b0};
            end
            warm_count <= warm_count + 1'b1;
            res_i      <= x_i;
            res_q      <= x_q;
            res_warm   <= 1'b1;
          end else begin
            volatility_i <= volatility_i + VolBits'(d_i) - VolBits'(dold_i);
            volatility_q <= volatility_q + VolBits'(d_q) - VolBits'(dold_q);
            res_warm     <= 1'b0;
          end
          ring_pos <= (WinBits'(ring_pos) + 1'b1 >= window_len) ? '0 : ring_pos + 1'b1;
        end
        S_DIV_INIT: begin
          rem     <= RemBits'(dir_c);
          quo     <= '0;
          div_cnt <= 5'(ScBits - 1);
        end
        S_DIV: begin
          // one quotient bit per cycle, restoring
          quo     <= {quo[ScBits-2:0], div_sub};
          rem     <= div_sub ? (rem - RemBits'(vol_c)) << 1 : rem << 1;
          div_cnt <= div_cnt - 1'b1;
        end
        S_LIN_M, S_SQ_M, S_UPD_M: prod <= $signed({1'b0, mul_a}) * mul_b;
        S_LIN: lin <= lin_acc[ProdBits-1] ? '0 : lin_acc[ScBits+15:16];
        S_SQ:  sc  <= prod_rnd[ScBits+15:16];
        S_UPD: begin
          if (comp) begin
            average_q <= avg_new;
            res_q     <= out_sat;
          end else begin
            average_i <= avg_new;
            res_i     <= out_sat;
          end
          comp <= ~comp;
        end
        S_DONE: if (!out_valid || !out_stall) begin
          out_i     <= res_i;
          out_q     <= res_q;
          warming   <= res_warm;
          out_valid <= 1'b1;
        end
        default: ;
      endcase

      if (accept) begin
        x_i <= sample_i;
        x_q <= sample_q;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/amai_ram.sv =====
// Generic single write, single read RAM with registered read data.
`default_nettype none
module amai_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/amai_checker.sv =====
// Port-level checks for the adaptive moving average block, bound to the top level.
`default_nettype none
module amai_checker
  import amai_pkg::*;
(
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic signed [SampleBits-1:0] out_i,
  input wire logic signed [SampleBits-1:0] out_q,
  input wire logic                         warming
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_i) && $stable(out_q) && $stable(warming))
    else $error("stalled result changed");

  // an accepted request keeps the input side busy
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input ready too soon after a request");

  // reset leaves the block idle with no result
  assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  // a new result cannot appear the cycle after a request is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared without processing time");

endmodule

bind adaptive_moving_average_iq amai_checker u_amai_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_i     (out_i),
  .out_q     (out_q),
  .warming   (warming)
);
`default_nettype wire

// ===== bench/adaptive_moving_average_iq_tb.sv =====
// Self-checking bench for the I/Q adaptive moving average block.
module adaptive_moving_average_iq_tb;
  import amai_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int DrainCycles = 80;

  typedef struct packed {
    logic signed [SampleBits-1:0] i;
    logic signed [SampleBits-1:0] q;
    logic                         warm;
  } iq_result_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [SampleBits-1:0] sample_i;
  logic signed [SampleBits-1:0] sample_q;
  logic                         channel_start;
  logic                         out_valid;
  logic                         out_stall;
  logic signed [SampleBits-1:0] out_i;
  logic signed [SampleBits-1:0] out_q;
  logic                         warming;
  logic                         cfg_we;
  logic [CfgIdxBits-1:0]        cfg_index;
  logic [ScBits-1:0]            cfg_data;

  adaptive_moving_average_iq u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_i(sample_i), .sample_q(sample_q), .channel_start(channel_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_i(out_i), .out_q(out_q), .warming(warming),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the block's registers and filter state.
  logic [6:0]          reg_period;
  logic [ScBits-1:0]   reg_fast;
  logic [ScBits-1:0]   reg_slow;
  longint              hist_x [MaxWindow][2];
  longint              hist_d [MaxWindow][2];
  longint              vol [2];
  longint              avg [2];
  int                  warm_count;
  int                  ring_pos;
  int                  win_len;

  iq_result_t          expected_outputs[$];
  int unsigned         cycle_count;
  int unsigned         mismatches;
  int unsigned         results_seen;
  int unsigned         requests_sent;
  int unsigned         filtered_seen;
  int unsigned         burst_left;
  int unsigned         stall_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Move one component's average toward x; return the saturated output.
  function automatic longint smooth_component(int c, longint x, longint dir);
    longint fs, ss, er, acc, lin, sc, o;
    fs = (reg_fast > ScOne) ? 65536 : reg_fast;
    ss = (reg_slow > ScOne) ? 65536 : reg_slow;
    er = 0;
    if (vol[c] != 0) begin
      er = (dir << 16) / vol[c];
      if (er > 65536) er = 65536;
    end
    acc = (ss << 16) + er * (fs - ss) + 32768;
    if (acc < 0) acc = 0;
    lin = acc >>> 16;
    sc = (lin * lin + 32768) >>> 16;
    avg[c] = avg[c] + ((sc * (x * 65536 - avg[c]) + 32768) >>> 16);
    o = (avg[c] + 32768) >>> 16;
    if (o > 32767) o = 32767;
    if (o < -32768) o = -32768;
    return o;
  endfunction

  // Advance the shadow state by one accepted request and queue its result.
  function automatic void kama_predict(logic signed [SampleBits-1:0] si,
                                       logic signed [SampleBits-1:0] sq, logic cs);
    longint x [2];
    longint d [2];
    longint dir [2];
    longint o [2];
    int prev;
    iq_result_t r;
    x[0] = si;
    x[1] = sq;
    if (cs) warm_count = 0;
    if (warm_count == 0) begin
      win_len = (reg_period == 0) ? 1 : (reg_period > MaxWindow) ? MaxWindow : reg_period;
      ring_pos = 0;
      vol[0] = 0;
      vol[1] = 0;
    end
    prev = (ring_pos == 0) ? win_len - 1 : ring_pos - 1;
    for (int c = 0; c < 2; c++) begin
      d[c] = (warm_count == 0) ? 0 :
             (x[c] >= hist_x[prev][c] ? x[c] - hist_x[prev][c] : hist_x[prev][c] - x[c]);
      dir[c] = x[c] >= hist_x[ring_pos][c] ? x[c] - hist_x[ring_pos][c]
                                            : hist_x[ring_pos][c] - x[c];
    end
    if (warm_count < win_len) begin
      vol[0] += d[0];
      vol[1] += d[1];
      if (warm_count == win_len - 1) begin
        avg[0] = x[0] * 65536;
        avg[1] = x[1] * 65536;
      end
      warm_count++;
      r.i = si;
      r.q = sq;
      r.warm = 1'b1;
    end else begin
      for (int c = 0; c < 2; c++) begin
        vol[c] = vol[c] + d[c] - hist_d[ring_pos][c];
        o[c] = smooth_component(c, x[c], dir[c]);
      end
      r.i = o[0][SampleBits-1:0];
      r.q = o[1][SampleBits-1:0];
      r.warm = 1'b0;
    end
    for (int c = 0; c < 2; c++) begin
      hist_x[ring_pos][c] = x[c];
      hist_d[ring_pos][c] = d[c];
    end
    ring_pos = (ring_pos + 1 >= win_len) ? 0 : ring_pos + 1;
    expected_outputs.push_back(r);
  endfunction

  // Offer one request, hold it until accepted, then maybe drop valid for a gap.
  task automatic send_sample(logic signed [SampleBits-1:0] si,
                             logic signed [SampleBits-1:0] sq, logic cs);
    int unsigned gap;
    in_valid <= 1'b1;
    sample_i <= si;
    sample_q <= sq;
    channel_start <= cs;
    do @(posedge clk); while (in_stall);
    kama_predict(si, sq, cs);
    requests_sent++;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 120) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid, wait for the block to drain, then write one register.
  task automatic write_reg(cfg_idx_t idx, logic [ScBits-1:0] val);
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WINDOW:  reg_period = val[6:0];
      CFG_FAST_SC: reg_fast = val;
      CFG_SLOW_SC: reg_slow = val;
      default: ;
    endcase
  endtask

  task automatic send_channel(int len, int shape);
    logic signed [SampleBits-1:0] si, sq;
    si = 16'($urandom);
    sq = 16'($urandom);
    for (int k = 0; k < len; k++) begin
      case (shape)
        0: begin
          si = 16'($urandom);
          sq = 16'($urandom);
        end
        1: begin
          si = si + $signed(16'($urandom_range(0, 400)) - 16'sd200);
          sq = sq + $signed(16'($urandom_range(0, 400)) - 16'sd200);
        end
        2: ;  // constant: zero volatility
        default: begin
          si = si + 16'sd37;
          sq = sq - 16'sd91;
        end
      endcase
      send_sample(si, sq, k == 0);
    end
  endtask

  // Directed: extremes at reset settings; first sample starts a channel without a flag.
  task automatic test_reset_defaults();
    send_sample(16'sh7fff, -16'sh8000, 1'b0);
    for (int k = 0; k < 11; k++)
      send_sample(k[0] ? 16'sh7fff : -16'sh8000, k[0] ? -16'sh8000 : 16'sh7fff, 1'b0);
    send_sample(16'sh0000, 16'shffff, 1'b0);
    send_sample(-16'sh0001, 16'sh5555, 1'b0);
  endtask

  // Window length: shortest, longest, zero and above range; mid-channel write is latched.
  task automatic test_window_extremes();
    write_reg(CFG_WINDOW, 17'd1);
    send_channel(4, 0);
    write_reg(CFG_WINDOW, 17'd0);
    send_channel(3, 2);
    write_reg(CFG_WINDOW, 17'd127);
    send_channel(70, 1);
    write_reg(CFG_WINDOW, 17'd64);
    send_channel(66, 3);
    write_reg(CFG_WINDOW, 17'd2);
    send_sample(16'sh1234, 16'sh4321, 1'b0);  // still in the 64-wide channel
    send_channel(5, 0);
  endtask

  // Smoothing constants at full scale, above range and zero; zero-volatility path.
  task automatic test_constants();
    write_reg(CFG_WINDOW, 17'd3);
    write_reg(CFG_FAST_SC, 17'd65536);
    write_reg(CFG_SLOW_SC, 17'h1ffff);
    send_channel(6, 2);
    send_channel(6, 0);
    write_reg(CFG_FAST_SC, 17'd0);
    write_reg(CFG_SLOW_SC, 17'd1);
    send_channel(6, 1);
    write_reg(CFG_FAST_SC, 17'h1ffff);
    write_reg(CFG_SLOW_SC, 17'd0);
    send_channel(6, 3);
  endtask

  // Random channels with random content, settings changed between phases; some noise.
  task automatic test_random_channels();
    int unsigned start;
    int len;
    start = requests_sent;
    while (requests_sent - start < 800) begin
      if ($urandom_range(0, 15) == 0) begin
        write_reg(CFG_WINDOW, $urandom_range(0, 9) == 0 ? 17'($urandom_range(0, 127))
                                                       : 17'($urandom_range(1, 8)));
        write_reg(CFG_FAST_SC, $urandom_range(0, 5) == 0 ? 17'($urandom)
                                                        : 17'($urandom_range(1, 65536)));
        write_reg(CFG_SLOW_SC, $urandom_range(0, 5) == 0 ? 17'($urandom)
                                                        : 17'($urandom_range(1, 65536)));
      end
      if ($urandom_range(0, 9) == 0) begin
        send_sample(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(1, 3 * (reg_period > MaxWindow ? MaxWindow : reg_period) + 12);
        send_channel(len, $urandom_range(0, 3));
      end
    end
  endtask

  // Receiver stall pattern: switch among no stall, random stall and long holds.
  always @(posedge clk) begin
    if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      2: out_stall <= ($urandom_range(0, 19) == 0) ? ~out_stall : out_stall;
      default: out_stall <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    iq_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (!warming) filtered_seen++;
      if (expected_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: i=%0d q=%0d warming=%0b", out_i, out_q, warming);
      end else begin
        exp_r = expected_outputs.pop_front();
        if (out_i !== exp_r.i || out_q !== exp_r.q || warming !== exp_r.warm) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at result %0d: expected i=%0d q=%0d warming=%0b,",
                      " got i=%0d q=%0d warming=%0b"},
                     results_seen, exp_r.i, exp_r.q, exp_r.warm, out_i, out_q, warming);
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("adaptive_moving_average_iq_tb: FAIL");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
    mismatches = 0;
    results_seen = 0;
    filtered_seen = 0;
    requests_sent = 0;
    burst_left = 4;
    stall_mode = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    sample_i = '0;
    sample_q = '0;
    channel_start = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_WINDOW;
    cfg_data = '0;
    reg_period = 7'd10;
    reg_fast = 17'd43691;
    reg_slow = 17'd4228;
    warm_count = 0;
    ring_pos = 0;
    win_len = 1;
    vol[0] = 0;
    vol[1] = 0;
    avg[0] = 0;
    avg[1] = 0;
    for (int k = 0; k < MaxWindow; k++)
      for (int c = 0; c < 2; c++) begin
        hist_x[k][c] = 0;
        hist_d[k][c] = 0;
      end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_window_extremes();
    test_constants();
    test_random_channels();

    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (expected_outputs.size() != 0) mismatches++;

    $display("sent %0d requests, checked %0d results (%0d filtered), %0d mismatches",
             requests_sent, results_seen, filtered_seen, mismatches);
    $display("covered window lengths 0..127, constants 0..max, zero volatility, restarts");
    if (mismatches == 0) begin
      $display("adaptive_moving_average_iq_tb: PASS");
    end else begin
      $display("adaptive_moving_average_iq_tb: FAIL");
    end
    $finish;
  end

endmodule
